// ===== sv/m3i_pkg.sv =====
// shared widths, types and helpers for the 3x3 matrix inverse
package m3i_pkg;

  localparam int WORD_BITS     = 32;
  localparam int FRACTION_BITS = 16;

  localparam int PROD_W = 2 * WORD_BITS;
  localparam int ADJ_W  = 2 * WORD_BITS + 1;
  localparam int MAG_W  = 2 * WORD_BITS;
  localparam int DET_W  = 3 * WORD_BITS + 3;
  localparam int NUM_A  = MAG_W + 2 * FRACTION_BITS + 1;
  localparam int NUM_B  = DET_W + WORD_BITS + 1;
  localparam int NUM_W  = ((NUM_A > NUM_B) ? NUM_A : NUM_B) + 1;
  localparam int DQ_W   = ((DET_W > 2 * FRACTION_BITS) ? DET_W : 2 * FRACTION_BITS) + 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // adjugate entry k = m[a]*m[b] - m[c]*m[d], flat row-major indices
  localparam int ADJ_IDX [9][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  typedef struct packed {
    logic [8:0][MAG_W-1:0]     adj_mag;
    logic [8:0]                inv_neg;
    logic [DET_W-1:0]          dmag;
    logic                      singular;
    logic [WORD_BITS-1:0]      det_value;
    logic                      det_sat;
  } entry_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] value;
    logic                 sat;
  } sat_t;

  // clip a magnitude with sign to the signed word range; big means >= 2^WORD_BITS
  function automatic sat_t sat_word(input logic big, input logic [WORD_BITS-1:0] q,
                                    input logic neg);
    sat_t r;
    r.sat   = 1'b0;
    r.value = q;
    if (!neg) begin
      if (big || q[WORD_BITS-1]) begin
        r.sat   = 1'b1;
        r.value = {1'b0, {(WORD_BITS-1){1'b1}}};
      end
    end else begin
      if (big || (q[WORD_BITS-1] && (q[WORD_BITS-2:0] != '0))) begin
        r.sat   = 1'b1;
        r.value = {1'b1, {(WORD_BITS-1){1'b0}}};
      end else begin
        r.value = '0 - q;
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/m3i_if.sv =====
// request channels for matrices in and inverses out
interface m3i_in_if;
  logic valid;
  logic ready;
  logic signed [m3i_pkg::WORD_BITS-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, output ready);
endinterface

interface m3i_out_if;
  logic valid;
  logic ready;
  logic signed [m3i_pkg::WORD_BITS-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic signed [m3i_pkg::WORD_BITS-1:0] det_value;
  logic singular;
  logic saturated;
  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, det_value,
                  singular, saturated, input ready);
  modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, det_value,
                singular, saturated, output ready);
endinterface

// ===== sv/m3i_front.sv =====
// front pipeline: adjugate, determinant and classification
module m3i_front (
  input  logic           clk,
  input  logic           rst,
  m3i_in_if.sink         matrix,
  output m3i_pkg::entry_t ent,
  output logic           ent_valid,
  input  logic           ent_ready
);

  localparam int W = m3i_pkg::WORD_BITS;
  localparam int F = m3i_pkg::FRACTION_BITS;

  logic [6:0] v;
  logic       en;

  logic signed [W-1:0]                mi  [0:8];
  logic signed [W-1:0]                m   [0:8];
  logic signed [m3i_pkg::PROD_W-1:0]  p   [0:17];
  logic signed [W-1:0]                r1  [0:2];
  logic signed [m3i_pkg::ADJ_W-1:0]   a2  [0:8];
  logic signed [W-1:0]                r2  [0:2];
  logic signed [2*W:0]                plo [0:2];
  logic signed [2*W:0]                phi [0:2];
  logic signed [m3i_pkg::ADJ_W-1:0]   a3  [0:8];
  logic signed [m3i_pkg::DET_W-1:0]   t4  [0:2];
  logic signed [m3i_pkg::ADJ_W-1:0]   a4  [0:8];
  logic signed [m3i_pkg::DET_W-1:0]   det;
  logic signed [m3i_pkg::ADJ_W-1:0]   a5  [0:8];

  logic                               det_neg;
  logic [m3i_pkg::DET_W-1:0]          dmag;
  logic [m3i_pkg::DQ_W-1:0]           dsum;
  logic [m3i_pkg::DQ_W-1:0]           dq;
  m3i_pkg::sat_t                      dsat;
  m3i_pkg::entry_t                    ent_next;

  assign en           = !v[6] || ent_ready;
  assign matrix.ready = en;
  assign ent_valid    = v[6];

  assign mi[0] = matrix.m00;
  assign mi[1] = matrix.m01;
  assign mi[2] = matrix.m02;
  assign mi[3] = matrix.m10;
  assign mi[4] = matrix.m11;
  assign mi[5] = matrix.m12;
  assign mi[6] = matrix.m20;
  assign mi[7] = matrix.m21;
  assign mi[8] = matrix.m22;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[5:0], matrix.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        m[i] <= mi[i];
      end
      for (int k = 0; k < 9; k++) begin
        p[2*k]   <= m[m3i_pkg::ADJ_IDX[k][0]] * m[m3i_pkg::ADJ_IDX[k][1]];
        p[2*k+1] <= m[m3i_pkg::ADJ_IDX[k][2]] * m[m3i_pkg::ADJ_IDX[k][3]];
      end
      for (int j = 0; j < 3; j++) begin
        r1[j] <= m[j];
        r2[j] <= r1[j];
      end
      for (int k = 0; k < 9; k++) begin
        a2[k] <= m3i_pkg::ADJ_W'(p[2*k]) - m3i_pkg::ADJ_W'(p[2*k+1]);
        a3[k] <= a2[k];
        a4[k] <= a3[k];
        a5[k] <= a4[k];
      end
      // row 0 times cofactors 0, 3 and 6, split into low and high halves
      for (int j = 0; j < 3; j++) begin
        plo[j] <= r2[j] * $signed({1'b0, a2[3*j][W-1:0]});
        phi[j] <= r2[j] * $signed(a2[3*j][m3i_pkg::ADJ_W-1:W]);
        t4[j]  <= (m3i_pkg::DET_W'(phi[j]) <<< W) + m3i_pkg::DET_W'(plo[j]);
      end
      det <= t4[0] + t4[1] + t4[2];
      ent <= ent_next;
    end
  end

  always_comb begin
    det_neg = det[m3i_pkg::DET_W-1];
    dmag    = det_neg ? m3i_pkg::DET_W'(-det) : m3i_pkg::DET_W'(det);
    dsum    = m3i_pkg::DQ_W'(dmag) + (m3i_pkg::DQ_W'(1) << (2*F-1));
    dq      = dsum >> (2*F);
    dsat    = m3i_pkg::sat_word((dq >> W) != '0, dq[W-1:0], det_neg);
    ent_next.dmag      = dmag;
    ent_next.singular  = (det == '0);
    ent_next.det_value = dsat.value;
    ent_next.det_sat   = dsat.sat;
    for (int k = 0; k < 9; k++) begin
      ent_next.inv_neg[k] = a5[k][m3i_pkg::ADJ_W-1] ^ det_neg;
      ent_next.adj_mag[k] = a5[k][m3i_pkg::ADJ_W-1] ? m3i_pkg::MAG_W'(-a5[k])
                                                    : m3i_pkg::MAG_W'(a5[k]);
    end
  end

endmodule

// ===== sv/m3i_queue.sv =====
// short queue between the front and back pipelines
module m3i_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  m3i_pkg::entry_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output m3i_pkg::entry_t pop_data
);

  m3i_pkg::entry_t               mem [0:m3i_pkg::QUEUE_DEPTH-1];
  logic [m3i_pkg::QPTR_W-1:0]    wr_ptr;
  logic [m3i_pkg::QPTR_W-1:0]    rd_ptr;
  logic [m3i_pkg::QCNT_W-1:0]    count;
  logic                          push;
  logic                          pop;

  assign push_ready = (count != m3i_pkg::QCNT_W'(m3i_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == m3i_pkg::QPTR_W'(m3i_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == m3i_pkg::QPTR_W'(m3i_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== sv/m3i_back.sv =====
// back pipeline: nine pipelined dividers, saturation and output register
module m3i_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            ent_valid,
  output logic            ent_ready,
  input  m3i_pkg::entry_t ent,
  m3i_out_if.source       inverse
);

  localparam int W  = m3i_pkg::WORD_BITS;
  localparam int F  = m3i_pkg::FRACTION_BITS;
  localparam int NW = m3i_pkg::NUM_W;

  typedef struct packed {
    logic [m3i_pkg::DET_W:0] d2;
    logic [8:0]              inv_neg;
    logic                    singular;
    logic [W-1:0]            det_value;
    logic                    det_sat;
  } ctl_t;

  logic [W:0]    v;
  logic          en;
  ctl_t          ctl [0:W];
  logic [NW-1:0] rem [0:W][0:8];
  logic [W-1:0]  quo [0:W][0:8];
  logic [8:0]    ovf [0:W];

  logic                    ov;
  m3i_pkg::sat_t           lane [0:8];
  logic [8:0][W-1:0]       res;
  logic [8:0][W-1:0]       res_next;
  logic [W-1:0]            detv;
  logic                    sing;
  logic                    sat;
  logic                    sat_next;
  logic [m3i_pkg::DET_W:0] d2_in;

  assign en            = !ov || inverse.ready;
  assign ent_ready     = en;
  assign inverse.valid = ov;
  assign d2_in         = {ent.dmag, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      v  <= '0;
      ov <= 1'b0;
    end else if (en) begin
      v  <= {v[W-1:0], ent_valid};
      ov <= v[W];
    end
  end

  // numerator setup and overflow check
  always_ff @(posedge clk) begin
    if (en) begin
      ctl[0].d2        <= d2_in;
      ctl[0].inv_neg   <= ent.inv_neg;
      ctl[0].singular  <= ent.singular;
      ctl[0].det_value <= ent.det_value;
      ctl[0].det_sat   <= ent.det_sat;
      for (int k = 0; k < 9; k++) begin
        rem[0][k]    <= (NW'(ent.adj_mag[k]) << (2*F+1)) + NW'(ent.dmag);
        quo[0][k]    <= '0;
        ovf[0][k]    <= ((NW'(ent.adj_mag[k]) << (2*F+1)) + NW'(ent.dmag))
                        >= (NW'(d2_in) << W);
      end
    end
  end

  for (genvar s = 1; s <= W; s++) begin : g_div
    always_ff @(posedge clk) begin
      if (en) begin
        ctl[s] <= ctl[s-1];
        ovf[s] <= ovf[s-1];
        for (int k = 0; k < 9; k++) begin
          if (rem[s-1][k] >= (NW'(ctl[s-1].d2) << (W-s))) begin
            rem[s][k] <= rem[s-1][k] - (NW'(ctl[s-1].d2) << (W-s));
            quo[s][k] <= quo[s-1][k] | (W'(1) << (W-s));
          end else begin
            rem[s][k] <= rem[s-1][k];
            quo[s][k] <= quo[s-1][k];
          end
        end
      end
    end
  end

  always_comb begin
    sat_next = ctl[W].det_sat;
    for (int k = 0; k < 9; k++) begin
      lane[k]     = m3i_pkg::sat_word(ovf[W][k], quo[W][k], ctl[W].inv_neg[k]);
      res_next[k] = ctl[W].singular ? '0 : lane[k].value;
      sat_next    = sat_next | lane[k].sat;
    end
    if (ctl[W].singular) begin
      sat_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res  <= res_next;
      detv <= ctl[W].singular ? '0 : ctl[W].det_value;
      sing <= ctl[W].singular;
      sat  <= sat_next;
    end
  end

  assign inverse.r00       = res[0];
  assign inverse.r01       = res[1];
  assign inverse.r02       = res[2];
  assign inverse.r10       = res[3];
  assign inverse.r11       = res[4];
  assign inverse.r12       = res[5];
  assign inverse.r20       = res[6];
  assign inverse.r21       = res[7];
  assign inverse.r22       = res[8];
  assign inverse.det_value = detv;
  assign inverse.singular  = sing;
  assign inverse.saturated = sat;

endmodule

// ===== sv/matrix3x3_inverse.sv =====
// top level of the 3x3 fixed-point matrix inverse
// throughput: one matrix per cycle while the receiver keeps ready high, with a 7-stage front and 34-stage divider back
// the back divides one quotient bit per stage for nine lanes side by side
// a four-entry queue lets front and back stall independently
// reset clears all valid bits and the queue; payload registers are not reset
module matrix3x3_inverse (
  input  logic      clk,
  input  logic      rst,
  m3i_in_if.sink    matrix,
  m3i_out_if.source inverse
);

  m3i_pkg::entry_t f_ent;
  logic            f_valid;
  logic            f_ready;
  m3i_pkg::entry_t b_ent;
  logic            b_valid;
  logic            b_ready;

  m3i_front u_front (
    .clk       (clk),
    .rst       (rst),
    .matrix    (matrix),
    .ent       (f_ent),
    .ent_valid (f_valid),
    .ent_ready (f_ready)
  );

  m3i_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_ent),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_ent)
  );

  m3i_back u_back (
    .clk       (clk),
    .rst       (rst),
    .ent_valid (b_valid),
    .ent_ready (b_ready),
    .ent       (b_ent),
    .inverse   (inverse)
  );

  a_singular_det: assert property (@(posedge clk) disable iff (rst)
    inverse.valid && inverse.singular |-> inverse.det_value == '0 && !inverse.saturated)
    else $error("singular result with nonzero determinant or saturation");

  a_singular_inv: assert property (@(posedge clk) disable iff (rst)
    inverse.valid && inverse.singular |->
      inverse.r00 == '0 && inverse.r11 == '0 && inverse.r22 == '0 && inverse.r01 == '0)
    else $error("singular result with nonzero inverse");

  a_front_hold: assert property (@(posedge clk) disable iff (rst)
    f_valid && !f_ready |=> f_valid)
    else $error("front entry dropped while queue full");

endmodule

// ===== verif/tb_top.sv =====
// testbench for the 3x3 fixed-point matrix inverse: predicted results checked request by request
`timescale 1ns / 1ps

module tb_top;

  typedef logic signed [m3i_pkg::WORD_BITS-1:0] word_t;
  typedef logic signed [255:0] big_t;

  typedef struct {
    word_t m [9];
  } matrix_t;

  typedef struct {
    word_t r [9];
    word_t det_value;
    logic  singular;
    logic  saturated;
  } inverse_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  m3i_in_if  matrix ();
  m3i_out_if inverse ();

  matrix3x3_inverse uut (
    .clk     (clk),
    .rst     (rst),
    .matrix  (matrix.sink),
    .inverse (inverse.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  matrix_t  pending_q [$];
  inverse_t inverse_q [$];
  int       errors = 0;
  int       n_accepted = 0;
  int       n_checked = 0;
  int       n_singular = 0;
  int       n_sat = 0;
  bit       stim_done = 1'b0;
  int       send_gap = 0;
  int       recv_gap = 0;
  int       hold_off = 0;
  bit       hold_done = 1'b0;

  // clip a signed value to the word range
  function automatic word_t clip(input big_t v, inout logic sat);
    big_t hi, lo;
    hi = (big_t'(1) <<< (m3i_pkg::WORD_BITS - 1)) - 1;
    lo = -(big_t'(1) <<< (m3i_pkg::WORD_BITS - 1));
    if (v > hi) begin
      sat = 1'b1;
      return word_t'(hi);
    end
    if (v < lo) begin
      sat = 1'b1;
      return word_t'(lo);
    end
    return word_t'(v);
  endfunction

  function automatic inverse_t invert(input matrix_t a);
    inverse_t res;
    big_t e [9];
    big_t cof [9];
    big_t det, dmag, amag, q;
    logic sat;
    logic neg;
    e = '{default: 0};
    for (int i = 0; i < 9; i++) e[i] = big_t'(a.m[i]);
    for (int k = 0; k < 9; k++)
      cof[k] = e[m3i_pkg::ADJ_IDX[k][0]] * e[m3i_pkg::ADJ_IDX[k][1]]
             - e[m3i_pkg::ADJ_IDX[k][2]] * e[m3i_pkg::ADJ_IDX[k][3]];
    det = e[0] * cof[0] + e[1] * cof[3] + e[2] * cof[6];
    sat = 1'b0;
    res.singular = 1'b0;
    if (det == 0) begin
      for (int k = 0; k < 9; k++) res.r[k] = '0;
      res.det_value = '0;
      res.singular = 1'b1;
      res.saturated = 1'b0;
      return res;
    end
    dmag = (det < 0) ? -det : det;
    for (int k = 0; k < 9; k++) begin
      amag = (cof[k] < 0) ? -cof[k] : cof[k];
      neg = (cof[k] < 0) != (det < 0);
      q = ((amag <<< (2 * m3i_pkg::FRACTION_BITS + 1)) + dmag) / (dmag <<< 1);
      res.r[k] = clip(neg ? -q : q, sat);
    end
    q = (dmag + (big_t'(1) <<< (2 * m3i_pkg::FRACTION_BITS - 1)))
        >>> (2 * m3i_pkg::FRACTION_BITS);
    res.det_value = clip((det < 0) ? -q : q, sat);
    res.saturated = sat;
    return res;
  endfunction

  function automatic word_t rand_elem(input int mode);
    case (mode)
      0: return word_t'($urandom);
      1: return word_t'($urandom_range(0, 32'h0006_0000)) - word_t'(32'h0003_0000);
      2: return word_t'($urandom_range(0, 255)) - 128;
      default: begin
        case ($urandom_range(0, 5))
          0: return 32'sh7fff_ffff;
          1: return 32'sh8000_0000;
          2: return 0;
          3: return 32'sh0001_0000;
          4: return -32'sh0001_0000;
          default: return 1;
        endcase
      end
    endcase
  endfunction

  function automatic int rand_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  task automatic add_matrix(input word_t v [9]);
    matrix_t a;
    a.m = v;
    pending_q.push_back(a);
  endtask

  initial begin
    word_t v [9];
    int mode;
    add_matrix('{32'sh10000, 0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000});
    add_matrix('{0, 0, 0, 0, 0, 0, 0, 0, 0});
    add_matrix('{32'sh10000, 32'sh20000, 32'sh30000, 32'sh20000, 32'sh40000, 32'sh60000,
                 1, 2, 3});
    add_matrix('{32'sh7fffffff, 0, 0, 0, 32'sh7fffffff, 0, 0, 0, 32'sh7fffffff});
    add_matrix('{32'sh80000000, 0, 0, 0, 32'sh80000000, 0, 0, 0, 32'sh80000000});
    add_matrix('{-1, -1, -1, -1, -1, -1, -1, -1, -1});
    add_matrix('{1, 0, 0, 0, 1, 0, 0, 0, 1});
    add_matrix('{32'sh100, 0, 0, 0, 32'sh100, 0, 0, 0, 32'sh100});
    add_matrix('{32'sh20000, 0, 0, 0, -32'sh40000, 0, 0, 0, 32'sh80000});
    add_matrix('{0, 32'sh10000, 0, 32'sh10000, 0, 0, 0, 0, 32'sh10000});
    add_matrix('{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff});
    add_matrix('{32'sh8000, 0, 0, 0, 32'sh8000, 0, 0, 0, 32'sh8000});
    add_matrix('{32'sh30000, 1, 0, 0, 32'sh30000, 0, 0, 0, -32'sh30000});
    for (int n = 0; n < 800; n++) begin
      mode = $urandom_range(0, 3);
      for (int i = 0; i < 9; i++) v[i] = rand_elem(mode);
      if ($urandom_range(0, 9) == 0) begin
        for (int i = 0; i < 3; i++) v[6 + i] = v[3 + i];
      end
      add_matrix(v);
    end
    stim_done = 1'b1;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      matrix.valid <= 1'b0;
      send_gap <= 0;
    end else if (!matrix.valid || matrix.ready) begin
      if (matrix.valid) begin
        inverse_q.push_back(invert(pending_q.pop_front()));
        n_accepted <= n_accepted + 1;
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        matrix.valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        matrix.valid <= 1'b1;
        send_gap <= rand_gap();
        {matrix.m00, matrix.m01, matrix.m02, matrix.m10, matrix.m11, matrix.m12,
         matrix.m20, matrix.m21, matrix.m22} <= {
          pending_q[0].m[0], pending_q[0].m[1], pending_q[0].m[2],
          pending_q[0].m[3], pending_q[0].m[4], pending_q[0].m[5],
          pending_q[0].m[6], pending_q[0].m[7], pending_q[0].m[8]};
      end else begin
        matrix.valid <= 1'b0;
      end
    end
  end

  initial begin
    matrix.valid = 1'b0;
    {matrix.m00, matrix.m01, matrix.m02, matrix.m10, matrix.m11, matrix.m12,
     matrix.m20, matrix.m21, matrix.m22} = '0;
    inverse.ready = 1'b0;
  end

  // long receiver hold-off once the stream is running, so the input stalls
  always @(posedge clk) begin
    if (!rst && !hold_done && n_accepted == 100 && hold_off == 0) hold_off <= 120;
    else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      if (hold_off == 1) hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    inverse_t want;
    if (rst) begin
      inverse.ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (inverse.valid && inverse.ready) begin
        if (inverse_q.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          want = inverse_q.pop_front();
          n_checked++;
          if (want.singular) n_singular++;
          if (want.saturated) n_sat++;
          if (inverse.r00 !== want.r[0]) begin
            $error("r00 exp %0d got %0d", want.r[0], inverse.r00); errors++; end
          if (inverse.r01 !== want.r[1]) begin
            $error("r01 exp %0d got %0d", want.r[1], inverse.r01); errors++; end
          if (inverse.r02 !== want.r[2]) begin
            $error("r02 exp %0d got %0d", want.r[2], inverse.r02); errors++; end
          if (inverse.r10 !== want.r[3]) begin
            $error("r10 exp %0d got %0d", want.r[3], inverse.r10); errors++; end
          if (inverse.r11 !== want.r[4]) begin
            $error("r11 exp %0d got %0d", want.r[4], inverse.r11); errors++; end
          if (inverse.r12 !== want.r[5]) begin
            $error("r12 exp %0d got %0d", want.r[5], inverse.r12); errors++; end
          if (inverse.r20 !== want.r[6]) begin
            $error("r20 exp %0d got %0d", want.r[6], inverse.r20); errors++; end
          if (inverse.r21 !== want.r[7]) begin
            $error("r21 exp %0d got %0d", want.r[7], inverse.r21); errors++; end
          if (inverse.r22 !== want.r[8]) begin
            $error("r22 exp %0d got %0d", want.r[8], inverse.r22); errors++; end
          if (inverse.det_value !== want.det_value) begin
            $error("det_value exp %0d got %0d", want.det_value, inverse.det_value);
            errors++;
          end
          if (inverse.singular !== want.singular) begin
            $error("singular exp %0b got %0b", want.singular, inverse.singular); errors++; end
          if (inverse.saturated !== want.saturated) begin
            $error("saturated exp %0b got %0b", want.saturated, inverse.saturated); errors++; end
        end
      end
      if (hold_off > 1 || (!hold_done && n_accepted == 100)) begin
        inverse.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        inverse.ready <= 1'b0;
      end else begin
        inverse.ready <= 1'b1;
        recv_gap <= rand_gap();
      end
    end
  end

  initial begin
    @(negedge rst);
    wait (stim_done && pending_q.size() == 0 && !matrix.valid && inverse_q.size() == 0);
    repeat (60) @(posedge clk);
    $display("checked %0d inverses, %0d singular, %0d with clipping", n_checked,
             n_singular, n_sat);
    if (errors == 0) $display("matrix3x3_inverse test passed");
    else $display("matrix3x3_inverse test failed");
    $finish;
  end

  initial begin
    #10ms;
    $display("matrix3x3_inverse test failed");
    $finish;
  end

endmodule
